>>> hdl/sensor_channel_table_statistics_defines.svh
// Assertion macros for the sensor channel table statistics block.
`ifndef SENSOR_CHANNEL_TABLE_STATISTICS_DEFINES_SVH
`define SENSOR_CHANNEL_TABLE_STATISTICS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SCTS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SCTS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/scts_pkg.sv
// Shared constants and types for the sensor channel table statistics block.
package scts_pkg;

    localparam int CHANNEL_COUNT = 32;
    localparam int CH_IDX_W      = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int TEMP_W        = 16;
    localparam int STATUS_W      = 2;
    localparam int CHAN_W        = 6;
    localparam int MASK_W        = 32;
    localparam int SUM_W         = TEMP_W + CH_IDX_W;
    localparam int CNT_W         = $clog2(CHANNEL_COUNT + 1);
    localparam int STEP_W        = $clog2(SUM_W + 1);

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OPEN = 2'd1;

    localparam logic [1:0] ACT_WRITE_TEMP   = 2'd0;
    localparam logic [1:0] ACT_WRITE_STATUS = 2'd1;

    localparam logic RC_OK  = 1'b0;
    localparam logic RC_OOB = 1'b1;

    typedef struct packed {
        logic                     valid;
        logic signed [TEMP_W-1:0] lo;
        logic signed [TEMP_W-1:0] hi;
        logic signed [SUM_W-1:0]  sum;
        logic [CNT_W-1:0]         count;
    } acc_t;

    typedef struct packed {
        logic                     wr_temp;
        logic                     wr_status;
        logic signed [TEMP_W-1:0] temperature;
        logic [STATUS_W-1:0]      status;
    } cell_wr_t;

endpackage

>>> hdl/scts_cell.sv
// One channel cell: holds a channel's entry and folds it into the passing statistics.
module scts_cell (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  scts_pkg::cell_wr_t               wr,
    input  scts_pkg::acc_t                   acc_in,
    output scts_pkg::acc_t                   acc_out,
    output logic signed [scts_pkg::TEMP_W-1:0] temperature,
    output logic [scts_pkg::STATUS_W-1:0]    status
);
    import scts_pkg::*;

    logic signed [TEMP_W-1:0] temp_reg;
    logic [STATUS_W-1:0]      status_reg;
    acc_t                     acc_reg;
    acc_t                     acc_next;

    always_comb begin
        acc_next = acc_in;
        if (status_reg == STATUS_OK) begin
            acc_next.count = acc_in.count + CNT_W'(1);
            acc_next.sum   = acc_in.sum + SUM_W'(temp_reg);
            if ((acc_in.count == '0) || (temp_reg < acc_in.lo)) begin
                acc_next.lo = temp_reg;
            end
            if ((acc_in.count == '0) || (temp_reg > acc_in.hi)) begin
                acc_next.hi = temp_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_reg      <= '0;
            status_reg    <= STATUS_OK;
            acc_reg.valid <= 1'b0;
        end else begin
            if (wr.wr_temp) begin
                temp_reg <= wr.temperature;
            end
            if (wr.wr_status) begin
                status_reg <= wr.status;
            end
            acc_reg <= acc_next;
        end
    end

    assign acc_out     = acc_reg;
    assign temperature = temp_reg;
    assign status      = status_reg;

endmodule

>>> hdl/scts_div.sv
// Iterative signed-by-unsigned divider for the average, one quotient bit per cycle.
module scts_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [scts_pkg::SUM_W-1:0] dividend,
    input  logic [scts_pkg::CNT_W-1:0]        divisor,
    output logic                              done,
    output logic signed [scts_pkg::TEMP_W-1:0] quotient
);
    import scts_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                neg_reg;
    logic                zero_reg;
    logic [CNT_W-1:0]    den_reg;
    logic [CNT_W:0]      rem_reg;
    logic [SUM_W-1:0]    quo_reg;
    logic [CNT_W:0]      rem_shift;
    logic                fits;
    logic [SUM_W-1:0]    mag;
    logic [SUM_W-1:0]    q_signed;

    assign mag       = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
    assign rem_shift = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                neg_reg  <= dividend[SUM_W-1];
                zero_reg <= (divisor == '0);
                den_reg  <= divisor;
                rem_reg  <= '0;
                quo_reg  <= mag;
            end else if (busy_reg) begin
                rem_reg  <= fits ? (rem_shift - {1'b0, den_reg}) : rem_shift;
                quo_reg  <= {quo_reg[SUM_W-2:0], fits};
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign q_signed = neg_reg ? (~quo_reg + SUM_W'(1)) : quo_reg;
    assign quotient = zero_reg ? '0 : q_signed[TEMP_W-1:0];
    assign done     = done_reg;

endmodule

>>> hdl/sensor_channel_table_statistics.sv
// Top level: channel table as a chain of cells with masked min, max, average and fault mask.
// The scan wave crosses one cell per cycle, then the divider forms the average from sum and count.
// A new item is taken only in the idle state, once the previous result is in the output register.
// A finished result waits in the output register while the next item runs.
// Reset: synchronous, active low; temperatures clear to zero and statuses to ok.
module sensor_channel_table_statistics (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_action,
    input  logic [scts_pkg::CHAN_W-1:0]        s_channel,
    input  logic signed [scts_pkg::TEMP_W-1:0] s_new_temperature,
    input  logic [scts_pkg::STATUS_W-1:0]      s_new_status,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_return_code,
    output logic signed [scts_pkg::TEMP_W-1:0] m_channel_temperature,
    output logic [scts_pkg::STATUS_W-1:0]      m_channel_status,
    output logic signed [scts_pkg::TEMP_W-1:0] m_minimum_temperature,
    output logic signed [scts_pkg::TEMP_W-1:0] m_maximum_temperature,
    output logic signed [scts_pkg::TEMP_W-1:0] m_average_temperature,
    output logic [scts_pkg::MASK_W-1:0]        m_fault_mask
);
    import scts_pkg::*;

    `include "sensor_channel_table_statistics_defines.svh"

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DIV, ST_DRAIN} state_t;

    state_t                   state_reg;
    logic                     start_reg;
    logic [CHAN_W-1:0]        channel_reg;
    logic                     inb_reg;
    logic signed [TEMP_W-1:0] lo_reg;
    logic signed [TEMP_W-1:0] hi_reg;
    logic                     m_valid_reg;
    logic                     rc_reg;
    logic signed [TEMP_W-1:0] ch_temp_reg;
    logic [STATUS_W-1:0]      ch_status_reg;
    logic signed [TEMP_W-1:0] min_reg;
    logic signed [TEMP_W-1:0] max_reg;
    logic signed [TEMP_W-1:0] avg_reg;
    logic [MASK_W-1:0]        fault_reg;

    acc_t                     wave [0:CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] wave_valid;
    logic signed [TEMP_W-1:0] cell_temp [0:CHANNEL_COUNT-1];
    logic [STATUS_W-1:0]      cell_status [0:CHANNEL_COUNT-1];
    logic [MASK_W-1:0]        fault_mask;
    logic                     s_accept;
    logic                     s_inb;
    logic                     div_start;
    logic                     div_done;
    logic signed [TEMP_W-1:0] div_quotient;
    logic                     load;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign s_inb    = ({1'b0, s_channel} < (CHAN_W + 1)'(CHANNEL_COUNT));

    assign wave[0] = '{valid: start_reg, lo: '0, hi: '0, sum: '0, count: '0};

    for (genvar i = 0; i < CHANNEL_COUNT; i++) begin : g_cell
        cell_wr_t wr;
        assign wr.wr_temp     = s_accept && s_inb && (s_channel == CHAN_W'(i))
                                && (s_action == ACT_WRITE_TEMP);
        assign wr.wr_status   = s_accept && s_inb && (s_channel == CHAN_W'(i))
                                && (s_action == ACT_WRITE_STATUS);
        assign wr.temperature = s_new_temperature;
        assign wr.status      = s_new_status;

        scts_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .wr          (wr),
            .acc_in      (wave[i]),
            .acc_out     (wave[i+1]),
            .temperature (cell_temp[i]),
            .status      (cell_status[i])
        );

        assign wave_valid[i] = wave[i+1].valid;
    end

    for (genvar i = 0; i < MASK_W; i++) begin : g_fault
        if (i < CHANNEL_COUNT) begin : g_live
            assign fault_mask[i] = (cell_status[i] != STATUS_OK);
        end else begin : g_none
            assign fault_mask[i] = 1'b0;
        end
    end

    assign div_start = (state_reg == ST_SCAN) && wave[CHANNEL_COUNT].valid;

    scts_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (wave[CHANNEL_COUNT].sum),
        .divisor  (wave[CHANNEL_COUNT].count),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign load = (state_reg == ST_DRAIN) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            start_reg <= s_accept;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        channel_reg <= s_channel;
                        inb_reg     <= s_inb;
                        state_reg   <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (div_start) begin
                        lo_reg    <= wave[CHANNEL_COUNT].lo;
                        hi_reg    <= wave[CHANNEL_COUNT].hi;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (load) begin
                        rc_reg        <= inb_reg ? RC_OK : RC_OOB;
                        ch_temp_reg   <= inb_reg ? cell_temp[channel_reg[CH_IDX_W-1:0]] : '0;
                        ch_status_reg <= inb_reg ? cell_status[channel_reg[CH_IDX_W-1:0]]
                                                 : STATUS_OPEN;
                        min_reg       <= lo_reg;
                        max_reg       <= hi_reg;
                        avg_reg       <= div_quotient;
                        fault_reg     <= fault_mask;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_return_code         = rc_reg;
    assign m_channel_temperature = ch_temp_reg;
    assign m_channel_status      = ch_status_reg;
    assign m_minimum_temperature = min_reg;
    assign m_maximum_temperature = max_reg;
    assign m_average_temperature = avg_reg;
    assign m_fault_mask          = fault_reg;

    `SCTS_ASSERT_NOW(a_single_wave, aclk, aresetn, 1'b1, $onehot0(wave_valid),
        "more than one scan wave in the cell chain")
    `SCTS_ASSERT_NOW(a_wave_in_scan, aclk, aresetn, wave[CHANNEL_COUNT].valid,
        state_reg == ST_SCAN, "scan wave left the chain outside the scan state")
    `SCTS_ASSERT_NOW(a_done_in_div, aclk, aresetn, div_done, state_reg == ST_DIV,
        "divider finished outside the divide state")
    `SCTS_ASSERT_NEXT(a_load_shows, aclk, aresetn, load, m_valid,
        "loaded result not presented")

endmodule

>>> bench/sensor_channel_table_statistics_checker.sv
// Checker: watches both channels, predicts each result from its own channel table, compares.
`timescale 1ns / 1ps

module sensor_channel_table_statistics_checker
    import scts_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [1:0]                  s_action,
    input  logic [CHAN_W-1:0]           s_channel,
    input  logic signed [TEMP_W-1:0]    s_new_temperature,
    input  logic [STATUS_W-1:0]         s_new_status,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic                        m_return_code,
    input  logic signed [TEMP_W-1:0]    m_channel_temperature,
    input  logic [STATUS_W-1:0]         m_channel_status,
    input  logic signed [TEMP_W-1:0]    m_minimum_temperature,
    input  logic signed [TEMP_W-1:0]    m_maximum_temperature,
    input  logic signed [TEMP_W-1:0]    m_average_temperature,
    input  logic [MASK_W-1:0]           m_fault_mask,
    output int                          fail_count,
    output int                          pending,
    output int                          checked,
    output int                          all_faulted_seen
);

    localparam int TABLE_DEPTH = 32;
    localparam int LIVE_CHANNELS = (CHANNEL_COUNT > TABLE_DEPTH) ? TABLE_DEPTH :
                                   (CHANNEL_COUNT < 1) ? 1 : CHANNEL_COUNT;
    localparam logic [MASK_W-1:0] LIVE_MASK = {MASK_W{1'b1}} >> (MASK_W - LIVE_CHANNELS);

    typedef struct {
        logic                     return_code;
        logic signed [TEMP_W-1:0] chan_temp;
        logic [STATUS_W-1:0]      chan_status;
        logic signed [TEMP_W-1:0] lowest;
        logic signed [TEMP_W-1:0] highest;
        logic signed [TEMP_W-1:0] mean;
        logic [MASK_W-1:0]        faults;
    } readout_t;

    logic signed [TEMP_W-1:0] temp_table [TABLE_DEPTH];
    logic [STATUS_W-1:0]      health_table [TABLE_DEPTH];
    readout_t                 expected_readouts [$];
    int                       fails;
    int                       matched;
    int                       faulted_hits;

    task automatic update_table(input logic [1:0] act, input logic [CHAN_W-1:0] ch,
                                input logic signed [TEMP_W-1:0] nt,
                                input logic [STATUS_W-1:0] ns, output readout_t r);
        int  lo;
        int  hi;
        int  sum;
        int  count;
        int  avg;
        int  t;
        logic inb;
        lo = 0;
        hi = 0;
        sum = 0;
        count = 0;
        avg = 0;
        inb = (ch < LIVE_CHANNELS);
        r.faults = '0;
        if (inb) begin
            if (act == ACT_WRITE_TEMP) begin
                temp_table[ch] = nt;
            end else if (act == ACT_WRITE_STATUS) begin
                health_table[ch] = ns;
            end
        end
        for (int i = 0; i < LIVE_CHANNELS; i++) begin
            if (health_table[i] != STATUS_OK) begin
                r.faults[i] = 1'b1;
            end else begin
                t = temp_table[i];
                if (count == 0) begin
                    lo = t;
                    hi = t;
                end else begin
                    if (t < lo) lo = t;
                    if (t > hi) hi = t;
                end
                sum += t;
                count++;
            end
        end
        if (count != 0) avg = sum / count;
        r.return_code = inb ? RC_OK : RC_OOB;
        r.chan_temp   = inb ? temp_table[ch] : '0;
        r.chan_status = inb ? health_table[ch] : STATUS_OPEN;
        r.lowest      = lo[TEMP_W-1:0];
        r.highest     = hi[TEMP_W-1:0];
        r.mean        = avg[TEMP_W-1:0];
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge aclk) begin
        readout_t want;
        readout_t got;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                temp_table[i]   = '0;
                health_table[i] = STATUS_OK;
            end
            expected_readouts.delete();
            fails        = 0;
            matched      = 0;
            faulted_hits = 0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{return_code: m_return_code, chan_temp: m_channel_temperature,
                        chan_status: m_channel_status, lowest: m_minimum_temperature,
                        highest: m_maximum_temperature, mean: m_average_temperature,
                        faults: m_fault_mask};
                if (expected_readouts.size() == 0) begin
                    $error("result with no item pending");
                    fails++;
                end else begin
                    want = expected_readouts.pop_front();
                    check_field("return_code", want.return_code, got.return_code);
                    check_field("channel_temperature", want.chan_temp, got.chan_temp);
                    check_field("channel_status", want.chan_status, got.chan_status);
                    check_field("minimum_temperature", want.lowest, got.lowest);
                    check_field("maximum_temperature", want.highest, got.highest);
                    check_field("average_temperature", want.mean, got.mean);
                    check_field("fault_mask", want.faults, got.faults);
                    matched++;
                end
            end
            if (s_valid && s_ready) begin
                update_table(s_action, s_channel, s_new_temperature, s_new_status, want);
                if (want.faults == LIVE_MASK) faulted_hits++;
                expected_readouts.push_back(want);
            end
        end
        fail_count       <= fails;
        pending          <= expected_readouts.size();
        checked          <= matched;
        all_faulted_seen <= faulted_hits;
    end

endmodule

>>> bench/sensor_channel_table_statistics_test.sv
// Testbench top: clock, reset, stimulus and receiver stalls for the channel table block.
`timescale 1ns / 1ps

module sensor_channel_table_statistics_test;
    import scts_pkg::*;

    localparam logic [1:0]          ACT_READ       = 2'd2;
    localparam logic [1:0]          ACT_READ_ALIAS = 2'd3;
    localparam logic [STATUS_W-1:0] STATUS_SHORTED = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_CODE3   = 2'd3;
    localparam int RANDOM_ITEMS    = 950;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int DRAIN_CYCLES    = 80;
    localparam int HOLD_OFF_CYCLES = 800;
    localparam int HOLD_OFF_AT     = 5000;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [1:0]               s_action;
    logic [CHAN_W-1:0]        s_channel;
    logic signed [TEMP_W-1:0] s_new_temperature;
    logic [STATUS_W-1:0]      s_new_status;
    logic                     m_valid;
    logic                     m_ready;
    logic                     m_return_code;
    logic signed [TEMP_W-1:0] m_channel_temperature;
    logic [STATUS_W-1:0]      m_channel_status;
    logic signed [TEMP_W-1:0] m_minimum_temperature;
    logic signed [TEMP_W-1:0] m_maximum_temperature;
    logic signed [TEMP_W-1:0] m_average_temperature;
    logic [MASK_W-1:0]        m_fault_mask;

    int fail_count;
    int pending;
    int checked;
    int all_faulted_seen;
    int cycle_count = 0;
    int burst_left  = 0;
    int items_sent  = 0;
    int oob_sent    = 0;
    int directed_sent;

    sensor_channel_table_statistics DUT (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_action              (s_action),
        .s_channel             (s_channel),
        .s_new_temperature     (s_new_temperature),
        .s_new_status          (s_new_status),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_return_code         (m_return_code),
        .m_channel_temperature (m_channel_temperature),
        .m_channel_status      (m_channel_status),
        .m_minimum_temperature (m_minimum_temperature),
        .m_maximum_temperature (m_maximum_temperature),
        .m_average_temperature (m_average_temperature),
        .m_fault_mask          (m_fault_mask)
    );

    sensor_channel_table_statistics_checker table_checker (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_action              (s_action),
        .s_channel             (s_channel),
        .s_new_temperature     (s_new_temperature),
        .s_new_status          (s_new_status),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_return_code         (m_return_code),
        .m_channel_temperature (m_channel_temperature),
        .m_channel_status      (m_channel_status),
        .m_minimum_temperature (m_minimum_temperature),
        .m_maximum_temperature (m_maximum_temperature),
        .m_average_temperature (m_average_temperature),
        .m_fault_mask          (m_fault_mask),
        .fail_count            (fail_count),
        .pending               (pending),
        .checked               (checked),
        .all_faulted_seen      (all_faulted_seen)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic signed [TEMP_W-1:0] pick_temp();
        int v;
        case ($urandom_range(0, 9))
            0: v = 32767;
            1: v = -32768;
            2, 3: v = int'($urandom_range(0, 400)) - 200;
            default: v = $urandom;
        endcase
        return v[TEMP_W-1:0];
    endfunction

    function automatic logic [STATUS_W-1:0] pick_status();
        if ($urandom_range(0, 9) < 6) return STATUS_OK;
        return STATUS_W'($urandom_range(1, 3));
    endfunction

    function automatic logic [CHAN_W-1:0] pick_channel(input int oob_pct);
        if ($urandom_range(0, 99) < oob_pct) return CHAN_W'($urandom_range(CHANNEL_COUNT, 63));
        return CHAN_W'($urandom_range(0, CHANNEL_COUNT - 1));
    endfunction

    task automatic offer(input logic [1:0] act, input logic [CHAN_W-1:0] ch,
                         input logic signed [TEMP_W-1:0] nt, input logic [STATUS_W-1:0] ns);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 70);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 6);
        end
        burst_left--;
        s_valid           <= 1'b1;
        s_action          <= act;
        s_channel         <= ch;
        s_new_temperature <= nt;
        s_new_status      <= ns;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (ch >= CHANNEL_COUNT) oob_sent++;
    endtask

    task automatic random_item(input int oob_pct);
        logic [1:0]          act;
        logic [STATUS_W-1:0] ns;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: act = ACT_WRITE_TEMP;
            4, 5, 6: act = ACT_WRITE_STATUS;
            7, 8: act = ACT_READ;
            default: act = ACT_READ_ALIAS;
        endcase
        ns = (act == ACT_WRITE_STATUS) ? pick_status() : STATUS_W'($urandom_range(0, 3));
        offer(act, pick_channel(oob_pct), pick_temp(), ns);
    endtask

    task automatic fault_sweep();
        int start;
        int ch;
        start = $urandom_range(0, CHANNEL_COUNT - 1);
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
            ch = (start + i) % CHANNEL_COUNT;
            offer(ACT_WRITE_STATUS, CHAN_W'(ch), pick_temp(), STATUS_W'($urandom_range(1, 3)));
            if ($urandom_range(0, 7) == 0) random_item(10);
        end
        offer(ACT_READ, pick_channel(20), pick_temp(), STATUS_W'($urandom_range(0, 3)));
        offer(ACT_WRITE_TEMP, pick_channel(0), pick_temp(), STATUS_W'($urandom_range(0, 3)));
        if ($urandom_range(0, 1) == 0) begin
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                offer(ACT_WRITE_STATUS, CHAN_W'(i), pick_temp(), STATUS_OK);
            end
        end else begin
            repeat ($urandom_range(1, 4)) begin
                offer(ACT_WRITE_STATUS, pick_channel(0), pick_temp(), STATUS_OK);
            end
        end
    endtask

    task automatic extreme_fill();
        int mode;
        logic signed [TEMP_W-1:0] nt;
        mode = $urandom_range(0, 2);
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
            case (mode)
                0: nt = 16'sh7FFF;
                1: nt = 16'sh8000;
                default: nt = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            endcase
            offer(ACT_WRITE_TEMP, CHAN_W'(i), nt, STATUS_W'($urandom_range(0, 3)));
        end
        offer(ACT_READ, pick_channel(10), pick_temp(), STATUS_W'($urandom_range(0, 3)));
    endtask

    initial begin
        int m_mode;
        int span;
        int elapsed;
        bit held;
        m_ready <= 1'b0;
        elapsed = 0;
        held    = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            m_mode = $urandom_range(0, 3);
            span   = $urandom_range(10, 300);
            repeat (span) begin
                case (m_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 7) == 0);
                    default: m_ready <= elapsed[2];
                endcase
                @(posedge aclk);
                elapsed++;
            end
            if (!held && elapsed >= HOLD_OFF_AT) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
        end
    end

    initial begin
        int kind;
        aresetn           <= 1'b0;
        s_valid           <= 1'b0;
        s_action          <= ACT_READ;
        s_channel         <= '0;
        s_new_temperature <= '0;
        s_new_status      <= STATUS_OK;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        offer(ACT_READ, 6'd0, 16'sh0000, STATUS_OK);
        offer(ACT_WRITE_TEMP, 6'd0, 16'sh7FFF, STATUS_CODE3);
        offer(ACT_WRITE_TEMP, CHAN_W'(CHANNEL_COUNT - 1), 16'sh8000, STATUS_OK);
        offer(ACT_WRITE_TEMP, 6'd1, 16'shFFFF, STATUS_SHORTED);
        offer(ACT_READ, CHAN_W'(CHANNEL_COUNT - 1), 16'sh5555, STATUS_OK);
        offer(ACT_WRITE_STATUS, CHAN_W'(CHANNEL_COUNT - 1), 16'sh1234, STATUS_SHORTED);
        offer(ACT_WRITE_STATUS, 6'd1, 16'shAAAA, STATUS_CODE3);
        offer(ACT_READ_ALIAS, 6'd1, 16'sh7FFF, STATUS_OPEN);
        offer(ACT_WRITE_STATUS, 6'd0, 16'sh0000, STATUS_OPEN);
        offer(ACT_WRITE_TEMP, 6'd2, -16'sd3, STATUS_OK);
        offer(ACT_WRITE_TEMP, 6'd3, -16'sd2, STATUS_OK);
        offer(ACT_WRITE_TEMP, CHAN_W'(CHANNEL_COUNT), 16'sd1234, STATUS_OK);
        offer(ACT_WRITE_STATUS, 6'd63, 16'sh8000, STATUS_SHORTED);
        offer(ACT_READ_ALIAS, 6'd45, 16'sh7FFF, STATUS_CODE3);
        offer(ACT_READ, 6'd63, 16'shFFFF, STATUS_CODE3);
        offer(ACT_WRITE_STATUS, 6'd0, 16'sh0000, STATUS_OK);
        offer(ACT_WRITE_STATUS, 6'd1, 16'sh0000, STATUS_OK);
        offer(ACT_WRITE_STATUS, CHAN_W'(CHANNEL_COUNT - 1), 16'sh0000, STATUS_OK);
        offer(ACT_READ, 6'd0, 16'sh0000, STATUS_OK);
        directed_sent = items_sent;

        while (items_sent < directed_sent + RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3, 4, 5: repeat ($urandom_range(10, 30)) random_item(15);
                6: fault_sweep();
                7: extreme_fill();
                default: repeat ($urandom_range(5, 15)) random_item(50);
            endcase
        end
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d items (%0d out of bounds) over writes, status changes and reads",
                 items_sent, oob_sent);
        $display("checked %0d results, %0d of them with every channel faulted",
                 checked, all_faulted_seen);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
